// File: hw/rtl/pru_pkg.sv
// Shared constants and types for the pixel replicate upscaler.
// No dependencies; imported by every module of the block except the generic RAM.
`timescale 1ns / 1ps

package pru_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_FACTOR = 64;

  localparam int COL_W    = $clog2(MAX_WIDTH);       // column index bits
  localparam int WIDTH_W  = COL_W + 1;               // source_width register bits
  localparam int FACTOR_W = $clog2(MAX_FACTOR) + 1;  // scale_factor register bits
  localparam int LEFT_W   = $clog2(MAX_FACTOR);      // words still to emit after this one
  localparam int PIX_W    = 24;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // command codes
  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_REPLAY = 1'b1;

  // register index (paddr[2])
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // one input item after decode, as it travels to the emitter
  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic              row_done;
    logic [1:0]        pad;
    logic              pending;
    logic              err;
    logic [LEFT_W-1:0] left;
  } pru_item_t;

endpackage

// File: hw/rtl/pru_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hw/rtl/pru_emit.sv
// Output stage: holds one decoded item and sends its copies, one word per cycle while out_stall is low.
// Depends on pru_pkg.
`timescale 1ns / 1ps

module pru_emit
  import pru_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  pru_item_t item,
  output logic      done,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       row_end,
  output logic [1:0] pad_bytes,
  output logic       replay_pending,
  output logic       order_error,
  output logic       last
);

  logic              busy;
  pru_item_t         cur;
  logic [LEFT_W-1:0] left;
  logic              fin;

  assign fin  = (left == '0);
  assign done = busy && !out_stall && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= item;
      left <= item.left;
    end else if (busy && !out_stall && !fin) begin
      left <= left - 1'b1;
    end
  end

  assign out_valid      = busy;
  assign out_red        = cur.pix[23:16];
  assign out_green      = cur.pix[15:8];
  assign out_blue       = cur.pix[7:0];
  assign row_end        = fin && cur.row_done;
  assign pad_bytes      = (fin && cur.row_done) ? cur.pad : 2'd0;
  assign replay_pending = cur.pending;
  assign order_error    = cur.err;
  assign last           = fin;

endmodule

// File: hw/rtl/pixel_replicate_upscaler.sv
// Pixel replicate upscaler: top level with register port, decode and line buffer.
// Depends on pru_pkg, pru_ram and pru_emit.
`timescale 1ns / 1ps

// Integer nearest-neighbor upscaler for 24-bit pixels. Send one pixel word
// (command 0) per source column; each is stored in the line buffer and
// emitted scale_factor times. When a source row ends and scale_factor > 1,
// the block expects replay words (command 1), one per column, until the row
// has been repeated scale_factor-1 more times; replay_pending on the output
// tells which kind comes next. The last word of every output row carries
// row_end and pad_bytes, the zero bytes that bring the row to a multiple of
// four bytes. A word of the wrong kind yields one output word with
// order_error set and changes nothing. Rate: the emitter sends one output
// word per cycle while out_stall is low; an input word gives f copies, f
// being scale_factor with 0 read as 1 and above 64 read as 64. A word can
// be taken while the last one's copies are still sent; it waits in the
// decode stage for its line buffer read. Input is stalled during reset. The
// line buffer needs no clearing pass after reset. Registers: scale_factor
// at 0x0, source_width at 0x4; write them only while idle.
module pixel_replicate_upscaler
  import pru_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // input words
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  // output words
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              row_end,
  output logic [1:0]        pad_bytes,
  output logic              replay_pending,
  output logic              order_error,
  output logic              last
);

  // registers
  logic [FACTOR_W-1:0] scale_factor;
  logic [WIDTH_W-1:0]  source_width;

  // row state
  logic [COL_W-1:0]    column_index;
  logic [LEFT_W-1:0]   rows_to_replay;
  logic                in_replay;
  logic [COL_W-1:0]    column_index_next;
  logic [LEFT_W-1:0]   rows_to_replay_next;
  logic                in_replay_next;

  // decode stage, waiting for buffer data
  logic                a_valid;
  logic                a_from_ram;
  pru_item_t           a_item;
  pru_item_t           dec_item;
  pru_item_t           load_item;

  logic                accept;
  logic                a_move;
  logic                emit_done;
  logic                cfg_wr;
  logic [FACTOR_W-1:0] eff_f;
  logic [WIDTH_W-1:0]  eff_w;
  logic                row_done;
  logic                err;
  logic [1:0]          row_bytes_lo;
  logic                ram_we;
  logic                ram_re;
  logic [PIX_W-1:0]    ram_rdata;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= FACTOR_W'(1);
      source_width <= WIDTH_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SCALE: scale_factor <= pwdata[FACTOR_W-1:0];
        REG_WIDTH: source_width <= pwdata[WIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE: prdata = DATA_W'(scale_factor);
      REG_WIDTH: prdata = DATA_W'(source_width);
      default:   prdata = '0;
    endcase
  end

  // ---------------- effective settings ----------------
  // zero acts as one, anything past the maximum acts as the maximum
  always_comb begin
    if (scale_factor == '0) begin
      eff_f = FACTOR_W'(1);
    end else if (scale_factor > FACTOR_W'(MAX_FACTOR)) begin
      eff_f = FACTOR_W'(MAX_FACTOR);
    end else begin
      eff_f = scale_factor;
    end
    if (source_width == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (source_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = source_width;
    end
  end

  // output row is w*f*3 bytes; only its low two bits matter for padding
  assign row_bytes_lo = 2'(eff_w[1:0] * eff_f[1:0] * 2'd3);

  // ---------------- handshake ----------------
  // nothing is taken while in reset
  assign a_move   = a_valid && (!out_valid || emit_done);
  assign in_stall = rst || (a_valid && !a_move);
  assign accept   = in_valid && !in_stall;

  // ---------------- decode and state update ----------------
  assign row_done = ({1'b0, column_index} + 1'b1) >= eff_w;
  assign err      = (command == CMD_REPLAY) != in_replay;

  always_comb begin
    column_index_next   = column_index;
    rows_to_replay_next = rows_to_replay;
    in_replay_next      = in_replay;
    if (!err) begin
      if (row_done) begin
        column_index_next = '0;
      end else begin
        column_index_next = column_index + 1'b1;
      end
      if (row_done && command == CMD_PIXEL && eff_f > FACTOR_W'(1)) begin
        in_replay_next      = 1'b1;
        rows_to_replay_next = LEFT_W'(eff_f - 1'b1);
      end
      if (row_done && command == CMD_REPLAY) begin
        if (rows_to_replay <= LEFT_W'(1)) begin
          rows_to_replay_next = '0;
          in_replay_next      = 1'b0;
        end else begin
          rows_to_replay_next = rows_to_replay - 1'b1;
        end
      end
    end

    dec_item.pending = in_replay_next;
    dec_item.err     = err;
    if (err) begin
      dec_item.pix      = '0;
      dec_item.row_done = 1'b0;
      dec_item.pad      = 2'd0;
      dec_item.left     = '0;
    end else begin
      dec_item.pix      = {red, green, blue};
      dec_item.row_done = row_done;
      dec_item.pad      = 2'd0 - row_bytes_lo;
      dec_item.left     = LEFT_W'(eff_f - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      rows_to_replay <= '0;
      in_replay      <= 1'b0;
    end else if (accept) begin
      column_index   <= column_index_next;
      rows_to_replay <= rows_to_replay_next;
      in_replay      <= in_replay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item     <= dec_item;
      a_from_ram <= ram_re;
    end
  end

  // ---------------- line buffer ----------------
  // One access per accepted in-turn word; a read never shares a cycle with
  // its write, so no bypass is needed; read data holds until the next replay.
  assign ram_we = accept && !err && command == CMD_PIXEL;
  assign ram_re = accept && !err && command == CMD_REPLAY;

  pru_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (column_index),
    .wdata ({red, green, blue}),
    .rdata (ram_rdata)
  );

  always_comb begin
    load_item = a_item;
    if (a_from_ram) begin
      load_item.pix = ram_rdata;
    end
  end

  // ---------------- output ----------------
  pru_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (a_move),
    .item           (load_item),
    .done           (emit_done),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .row_end        (row_end),
    .pad_bytes      (pad_bytes),
    .replay_pending (replay_pending),
    .order_error    (order_error),
    .last           (last)
  );

endmodule

// File: tb/sv/tb_pixel_replicate_upscaler.sv
// Self-checking testbench for pixel_replicate_upscaler: directed and random command
// streams, with an in-bench predictor and a scoreboard. Depends on pru_pkg and the RTL.
`timescale 1ns / 1ps

module tb_pixel_replicate_upscaler;
  import pru_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // one output word as the scoreboard sees it
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       row_end;
    logic [1:0] pad;
    logic       pending;
    logic       err;
    logic       last;
  } out_word_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic              command;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic              row_end;
  logic [1:0]        pad_bytes;
  logic              replay_pending;
  logic              order_error;
  logic              last;

  pixel_replicate_upscaler dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .row_end        (row_end),
    .pad_bytes      (pad_bytes),
    .replay_pending (replay_pending),
    .order_error    (order_error),
    .last           (last)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the line buffer, column, replay counter
  // and the two registers as last written.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]    model_line [MAX_WIDTH];
  logic [COL_W-1:0]    model_col;
  logic [LEFT_W-1:0]   model_rows_left;
  logic                model_replaying;
  logic [FACTOR_W-1:0] reg_factor;
  logic [WIDTH_W-1:0]  reg_width;

  out_word_t expected_pixels[$];

  bit idle_enable;
  int mismatch_count;
  int words_sent;
  int pixels_checked;
  int order_errors_seen;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout: %0d words still expected", expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // register values as the datapath uses them: 0 acts as 1, big values clip
  function automatic int eff_factor();
    if (reg_factor == 0) return 1;
    if (reg_factor > MAX_FACTOR) return MAX_FACTOR;
    return int'(reg_factor);
  endfunction

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(reg_width);
  endfunction

  function automatic string word_text(input out_word_t wd);
    return $sformatf("rgb=%06h end=%b pad=%0d pend=%b err=%b last=%b", {wd.r, wd.g, wd.b},
                     wd.row_end, wd.pad, wd.pending, wd.err, wd.last);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Work out the output words one input word causes and queue them.
  task automatic upscale_word(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
    int              f;
    int              w;
    int              pad;
    logic            row_done;
    logic [PIX_W-1:0] pix;
    out_word_t       wd;
    f        = eff_factor();
    w        = eff_width();
    pad      = (4 - ((w * f * 3) & 3)) & 3;
    row_done = (int'(model_col) + 1 >= w);
    if ((cmd == CMD_REPLAY) != model_replaying) begin
      // wrong kind of word: one flagged word, state untouched
      wd         = '0;
      wd.pending = model_replaying;
      wd.err     = 1'b1;
      wd.last    = 1'b1;
      expected_pixels.push_back(wd);
    end else begin
      if (cmd == CMD_PIXEL) begin
        pix = {r, g, b};
        model_line[model_col] = pix;
        if (row_done) begin
          model_col = '0;
          if (f > 1) begin
            model_replaying = 1'b1;
            model_rows_left = LEFT_W'(f - 1);
          end
        end else begin
          model_col = model_col + 1'b1;
        end
      end else begin
        pix = model_line[model_col];
        if (row_done) begin
          model_col = '0;
          if (model_rows_left <= 1) begin
            model_rows_left = '0;
            model_replaying = 1'b0;
          end else begin
            model_rows_left = model_rows_left - 1'b1;
          end
        end else begin
          model_col = model_col + 1'b1;
        end
      end
      for (int k = 0; k < f; k++) begin
        wd.r       = pix[23:16];
        wd.g       = pix[15:8];
        wd.b       = pix[7:0];
        wd.row_end = (k == f - 1) && row_done;
        wd.pad     = wd.row_end ? 2'(pad) : 2'd0;
        wd.pending = model_replaying;
        wd.err     = 1'b0;
        wd.last    = (k == f - 1);
        expected_pixels.push_back(wd);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: one word per call, held until taken.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    upscale_word(cmd, r, g, b);
    in_valid <= 1'b1;
    command  <= cmd;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_sent++;
  endtask

  task automatic send_random_word(input int noise_pct);
    logic cmd;
    cmd = model_replaying ? CMD_REPLAY : CMD_PIXEL;
    if ($urandom_range(0, 99) < noise_pct) cmd = ~cmd;
    send_word(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // let every expected word come out, with the input held idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write followed straight away by a read-back of the same register.
  task automatic program_reg(input logic idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SCALE) reg_factor = value[FACTOR_W-1:0];
    else reg_width = value[WIDTH_W-1:0];
    want = (idx == REG_SCALE) ? DATA_W'(reg_factor) : DATA_W'(reg_width);
    // read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      note_mismatch($sformatf("register %0d read %0h, expected %0h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, and the scoreboard.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {out_red, out_green, out_blue, row_end, pad_bytes, replay_pending, order_error,
             last};
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected word rgb=%06h", {got.r, got.g, got.b}));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want.err) order_errors_seen++;
        if (got !== want)
          note_mismatch($sformatf("word %0d exp %s, got %s", pixels_checked,
                                  word_text(want), word_text(got)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // factor 1: no replay at all; color extremes; a replay word out of turn
  task automatic test_unity_factor();
    program_reg(REG_SCALE, 32'd1);
    program_reg(REG_WIDTH, 32'd3);      // w*f = 3 -> pad 3
    send_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_word(CMD_REPLAY, 8'h12, 8'h34, 8'h56);   // nothing pending -> order error
    send_word(CMD_PIXEL, 8'hA5, 8'h5A, 8'hC3);
    wait_drained();
  endtask

  // factor 2: one replayed row; a pixel word while replay is pending
  task automatic test_replay_rows();
    program_reg(REG_SCALE, 32'd2);
    program_reg(REG_WIDTH, 32'd2);      // w*f = 4 -> pad 0
    send_word(CMD_PIXEL, 8'h80, 8'h01, 8'h7F);
    send_word(CMD_PIXEL, 8'h01, 8'hFE, 8'h80);
    send_word(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);    // replay pending -> order error
    send_word(CMD_REPLAY, 8'h00, 8'hFF, 8'h00);
    send_word(CMD_REPLAY, 8'h00, 8'h00, 8'h00);
    wait_drained();
  endtask

  // zero in either register acts as one
  task automatic test_zero_registers();
    program_reg(REG_SCALE, 32'd0);
    program_reg(REG_WIDTH, 32'd1);      // pad 1
    send_word(CMD_PIXEL, 8'h55, 8'hAA, 8'h55);
    wait_drained();
    program_reg(REG_SCALE, 32'd2);
    program_reg(REG_WIDTH, 32'd0);      // acts as 1, w*f = 2 -> pad 2
    send_word(CMD_PIXEL, 8'hAA, 8'h55, 8'hAA);
    send_word(CMD_REPLAY, 8'hFF, 8'hFF, 8'hFF);
    wait_drained();
  endtask

  // width above the maximum acts as the maximum; shrink mid-row ends the row early
  task automatic test_width_clip();
    program_reg(REG_SCALE, 32'd1);
    program_reg(REG_WIDTH, 32'h7FF);
    repeat (3) send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();
    // column already past the new last column: next pixel closes the row
    program_reg(REG_WIDTH, 32'd2);
    send_word(CMD_PIXEL, 8'h0F, 8'hF0, 8'h3C);
    wait_drained();
  endtask

  // register changes while a row or a replay is under way
  task automatic test_midrow_reconfig();
    program_reg(REG_SCALE, 32'd3);
    program_reg(REG_WIDTH, 32'd4);
    send_word(CMD_PIXEL, 8'h11, 8'h22, 8'h33);
    send_word(CMD_PIXEL, 8'h44, 8'h55, 8'h66);
    wait_drained();
    program_reg(REG_WIDTH, 32'd3);      // row now ends at column 2
    send_word(CMD_PIXEL, 8'h77, 8'h88, 8'h99);
    send_word(CMD_REPLAY, 8'h00, 8'h00, 8'h00);
    wait_drained();
    program_reg(REG_SCALE, 32'd1);      // two rows still owed; copies drop to one
    program_reg(REG_WIDTH, 32'd2);
    repeat (3) send_word(CMD_REPLAY, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();
  endtask

  // factor above the maximum acts as 64: one column, 64 copies, 63 replayed rows
  task automatic test_max_factor();
    program_reg(REG_SCALE, 32'h7F);
    program_reg(REG_WIDTH, 32'd1);      // 64*3 bytes -> pad 0
    send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 63; i++) begin
      if (i == 30) send_word(CMD_PIXEL, 8'hDE, 8'hAD, 8'hBE);  // out of turn
      send_word(CMD_REPLAY, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    wait_drained();
  endtask

  // Pick new register values. During a replay the width may not grow, so
  // every column read back has been written in this row.
  task automatic random_reconfig();
    int pick;
    int which;
    logic [DATA_W-1:0] fval;
    logic [DATA_W-1:0] wval;
    pick = $urandom_range(0, 9);
    if (pick < 7) fval = $urandom_range(1, 4);
    else if (pick == 7) fval = 0;
    else fval = $urandom_range(5, 9);
    pick = $urandom_range(0, 9);
    if (model_replaying) wval = $urandom_range(1, eff_width());
    else if (pick < 8) wval = $urandom_range(1, 5);
    else if (pick == 8) wval = 0;
    else wval = $urandom_range(6, 12);
    which = $urandom_range(0, 2);
    if (which != 1) program_reg(REG_SCALE, fval);
    if (which != 0) program_reg(REG_WIDTH, wval);
  endtask

  // mostly well-formed rows and replays, with some words out of turn
  task automatic test_random_traffic(input int count);
    int left;
    int phase_len;
    left = count;
    while (left > 0) begin
      wait_drained();
      random_reconfig();
      phase_len = $urandom_range(8, 20);
      for (int i = 0; i < phase_len && left > 0; i++) begin
        send_random_word(10);
        left--;
      end
    end
    wait_drained();
  endtask

  // back-to-back words, no idling on either side
  task automatic test_steady_stream(input int count);
    idle_enable = 1'b0;
    wait_drained();
    program_reg(REG_SCALE, 32'd2);
    program_reg(REG_WIDTH, 32'd3);      // w*f = 6 -> pad 2
    for (int i = 0; i < count; i++) send_random_word(5);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    idle_enable       = 1'b1;
    mismatch_count    = 0;
    words_sent        = 0;
    pixels_checked    = 0;
    order_errors_seen = 0;
    model_col         = '0;
    model_rows_left   = '0;
    model_replaying   = 1'b0;
    reg_factor        = FACTOR_W'(1);
    reg_width         = WIDTH_W'(1);
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    command  <= CMD_PIXEL;
    red      <= 8'h00;
    green    <= 8'h00;
    blue     <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unity_factor();
    test_replay_rows();
    test_zero_registers();
    test_width_clip();
    test_midrow_reconfig();
    test_max_factor();
    test_random_traffic(25);
    test_steady_stream(20);

    repeat (20) @(posedge clk);
    $display("Sent %0d input words, checked %0d output words (%0d order errors).",
             words_sent, pixels_checked, order_errors_seen);
    $display("Covered factors 0..127 incl. clipping, widths 0..2047, mid-row reconfig.");
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words never seen", mismatch_count,
               expected_pixels.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pru_pkg.sv
hw/rtl/pru_ram.sv
hw/rtl/pru_emit.sv
hw/rtl/pixel_replicate_upscaler.sv
tb/sv/tb_pixel_replicate_upscaler.sv
